FILE: design/weighted_cell_centroid_core_macros.svh
// assertion macros shared by the design files
`ifndef WEIGHTED_CELL_CENTROID_CORE_MACROS_SVH
`define WEIGHTED_CELL_CENTROID_CORE_MACROS_SVH

// implication checked every cycle outside reset
`define WCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define WCC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: design/wcc_pkg.sv
`timescale 1ns / 1ps
package wcc_pkg;

	localparam int CoordW = 15;
	localparam int FracW = 8;
	localparam int AccW = 64;
	localparam int MassW = 63;
	localparam int IdxW = 8;
	localparam int InDataW = 104;
	localparam int OutDataW = 104;
	localparam logic [CoordW-1:0] CoordMax = 15'h7fff;
	localparam logic [AccW-1:0] AccLim = 64'h7fff_ffff_ffff_ffff;
	// ceil(2^21 / 6), exact for numerators below 2^19
	localparam logic [18:0] Div6Recip = 19'd349526;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAUSS,
		ST_DENS,
		ST_DENS2,
		ST_MOM,
		ST_CONTRIB,
		ST_DIV6,
		ST_QUOT,
		ST_ACCUM,
		ST_DIVIDE,
		ST_OUT
	} wcc_state_t;

	typedef struct packed {
		logic load;       // capture the triangle
		logic gauss;      // form gauss point of pt_sel
		logic dens;       // squares
		logic dens2;      // fourth powers
		logic mom;        // density and moments of one point
		logic contrib;    // one partial product step
		logic div6;       // load the three scaled products for the divide by six
		logic quot;       // one quotient digit of the divide by six
		logic accum;      // add to the sums
		logic div_start;  // start centroid division
		logic div_step;
		logic finish;     // form result and clear sums
		logic [1:0] pt_sel;
		logic [2:0] part_sel;
	} wcc_cmd_t;

	typedef struct packed {
		logic last;
		logic div_done;
	} wcc_sts_t;

endpackage

FILE: design/weighted_cell_centroid_core.sv
`timescale 1ns / 1ps
// Density-weighted centroid of a cell built from fan triangles. Each input word is one
// triangle (site, two boundary vertices); a triangle that is not last closes the input
// until it is added to the sums, so no new word is taken while one is in work: three
// gauss points run through one shared set of multipliers in gauss, square, fourth-power
// and moment steps, six 32x32 partial products scale the sums by the determinant, a load
// and four digit steps divide them by six, and a final step adds them to the sums. On the
// last triangle a 64-step restoring divider forms both centroid coordinates and the result
// then moves into the output register, later while it still holds a word not yet taken.
// A result word waits in the output register while the next item is accepted. The user
// must write density_mode only while the block is idle; the block does not enforce it.
module weighted_cell_centroid_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// site_x, site_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y, cell_index
	input  logic [wcc_pkg::InDataW-1:0] s_axis_tdata,
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// centroid_x, centroid_y, cell_mass, cell_index_out
	output logic [wcc_pkg::OutDataW-1:0] m_axis_tdata,
	// mass_error
	output logic m_axis_tuser
);
	import wcc_pkg::*;

	logic mode_q, busy, out_load, in_fire, out_free;
	logic [OutDataW-1:0] res_data;
	logic res_err;
	wcc_cmd_t cmd;
	wcc_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b1;
		else if (cfg_we) mode_q <= cfg_wdata;
	end

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	wcc_ctrl u_ctrl (.clk, .arst_n, .in_fire, .out_free, .sts, .busy, .out_load, .cmd);
	wcc_dp u_dp (.clk, .arst_n, .density_mode(mode_q), .in_data(s_axis_tdata),
		.in_last(s_axis_tlast), .cmd, .sts, .res_data, .res_err);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (out_load) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= res_data;
			m_axis_tuser <= res_err;
		end
	end
endmodule

FILE: design/wcc_ctrl.sv
`timescale 1ns / 1ps
`include "weighted_cell_centroid_core_macros.svh"
module wcc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_free,
	input  wcc_pkg::wcc_sts_t sts,
	output logic busy,
	output logic out_load,
	output wcc_pkg::wcc_cmd_t cmd
);
	import wcc_pkg::*;

	wcc_state_t state_q, state_d;
	logic [1:0] pt_q, pt_d;
	logic [2:0] part_q, part_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pt_q <= '0;
			part_q <= '0;
		end else begin
			state_q <= state_d;
			pt_q <= pt_d;
			part_q <= part_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pt_d = pt_q;
		part_d = part_q;
		cmd = '0;
		cmd.pt_sel = pt_q;
		cmd.part_sel = part_q;
		busy = 1'b1;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = in_fire;
				pt_d = '0;
				if (in_fire) state_d = ST_GAUSS;
			end
			ST_GAUSS: begin
				cmd.gauss = 1'b1;
				state_d = ST_DENS;
			end
			ST_DENS: begin
				cmd.dens = 1'b1;
				state_d = ST_DENS2;
			end
			ST_DENS2: begin
				cmd.dens2 = 1'b1;
				state_d = ST_MOM;
			end
			ST_MOM: begin
				cmd.mom = 1'b1;
				if (pt_q == 2'd2) begin
					state_d = ST_CONTRIB;
					part_d = '0;
				end else begin
					pt_d = pt_q + 2'd1;
					state_d = ST_GAUSS;
				end
			end
			ST_CONTRIB: begin
				// three sums, each in two 32-bit slices, by the magnitude of det
				cmd.contrib = 1'b1;
				part_d = part_q + 3'd1;
				if (part_q == 3'd5) state_d = ST_DIV6;
			end
			ST_DIV6: begin
				cmd.div6 = 1'b1;
				part_d = '0;
				state_d = ST_QUOT;
			end
			ST_QUOT: begin
				// four 16-bit quotient digits
				cmd.quot = 1'b1;
				part_d = part_q + 3'd1;
				if (part_q == 3'd3) state_d = ST_ACCUM;
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d = sts.last ? ST_DIVIDE : ST_IDLE;
				cmd.div_start = sts.last;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`WCC_ASSERT_NXT(a_load_leaves_idle, clk, arst_n, in_fire && !busy, state_q == ST_GAUSS)
	`WCC_ASSERT_IMP(a_out_only_in_out, clk, arst_n, out_load, state_q == ST_OUT)
	`WCC_ASSERT_IMP(a_pt_range, clk, arst_n, state_q == ST_MOM, pt_q != 2'd3)
endmodule

FILE: design/wcc_dp.sv
`timescale 1ns / 1ps
`include "weighted_cell_centroid_core_macros.svh"
module wcc_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic density_mode,
	input  logic [wcc_pkg::InDataW-1:0] in_data,
	input  logic in_last,
	input  wcc_pkg::wcc_cmd_t cmd,
	output wcc_pkg::wcc_sts_t sts,
	output logic [wcc_pkg::OutDataW-1:0] res_data,
	output logic res_err
);
	import wcc_pkg::*;

	// n / 6 for n below 6 * 2^16: quotient in the upper 16 bits, remainder in the low 3
	function automatic logic [18:0] div6_digit(input logic [18:0] n);
		logic [37:0] p;
		logic [15:0] q;
		logic [18:0] r;
		p = 38'(n) * 38'(Div6Recip);
		q = p[36:21];
		r = n - 19'(q) * 19'd6;
		return {q, r[2:0]};
	endfunction

	logic [CoordW-1:0] sx_q, sy_q, ax_q, ay_q, bx_q, by_q;
	logic [IdxW-1:0] idx_q;
	logic last_q;
	logic [CoordW-1:0] gx_q, gy_q;
	logic [29:0] x2_q, y2_q;
	logic [60:0] d4_q;
	logic [49:0] sm_q;
	logic [64:0] smx_q, smy_q;
	logic neg_q;
	logic [31:0] mag_q;
	logic [97:0] pm_q, px_q, py_q;
	logic [63:0] cm_q, cx_q, cy_q;
	logic signed [AccW-1:0] mass_q, momx_q, momy_q;

	// gauss point: (4p+q+r+3)/6
	logic [CoordW-1:0] gp, gq, gr, hp, hq, hr;
	logic [17:0] gnum, hnum;
	logic [18:0] gdig, hdig;
	logic [CoordW-1:0] gdiv, hdiv;
	always_comb begin
		case (cmd.pt_sel)
			2'd0: begin gp = ax_q; gq = bx_q; hp = ay_q; hq = by_q; end
			2'd1: begin gp = bx_q; gq = ax_q; hp = by_q; hq = ay_q; end
			default: begin gp = sx_q; gq = ax_q; hp = sy_q; hq = ay_q; end
		endcase
		gr = (cmd.pt_sel == 2'd2) ? bx_q : sx_q;
		hr = (cmd.pt_sel == 2'd2) ? by_q : sy_q;
		gnum = 18'({gp, 2'b00}) + 18'(gq) + 18'(gr) + 18'd3;
		hnum = 18'({hp, 2'b00}) + 18'(hq) + 18'(hr) + 18'd3;
		gdig = div6_digit({1'b0, gnum});
		hdig = div6_digit({1'b0, hnum});
		gdiv = gdig[17:3];
		hdiv = hdig[17:3];
	end

	// determinant, 32-bit signed range
	logic signed [16:0] dax, day, dbx, dby;
	logic signed [33:0] det;
	assign dax = $signed({2'b0, ax_q}) - $signed({2'b0, sx_q});
	assign day = $signed({2'b0, ay_q}) - $signed({2'b0, sy_q});
	assign dbx = $signed({2'b0, bx_q}) - $signed({2'b0, sx_q});
	assign dby = $signed({2'b0, by_q}) - $signed({2'b0, sy_q});
	assign det = dax * dby - dbx * day;

	logic [60:0] dsel;
	assign dsel = density_mode ? d4_q : 61'(1 << FracW);

	// partial product: one 32x32 slice per step
	logic [64:0] opnd;
	logic [31:0] slice;
	logic [63:0] pprod;
	always_comb begin
		case (cmd.part_sel[2:1])
			2'd0: opnd = 65'(sm_q);
			2'd1: opnd = smx_q;
			default: opnd = smy_q;
		endcase
		slice = cmd.part_sel[0] ? 32'(opnd[64:32]) : opnd[31:0];
		pprod = mag_q * slice;
	end

	function automatic logic [63:0] shr_sat(input logic [97:0] p);
		logic [73:0] r;
		r = p[97:24];
		return (r[73:63] != '0) ? 64'h7fff_ffff_ffff_ffff : {1'b0, r[62:0]};
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
		if (s < -65'sh0_7fff_ffff_ffff_ffff) return -64'sh7fff_ffff_ffff_ffff;
		return s[63:0];
	endfunction

	// quotient by six, one 16-bit digit per step from the top of the dividend
	logic [63:0] qm_q, qx_q, qy_q;
	logic [2:0] rm_q, rx_q, ry_q;
	logic [18:0] dm, dx, dy;
	assign dm = div6_digit({rm_q, cm_q[63:48]});
	assign dx = div6_digit({rx_q, cx_q[63:48]});
	assign dy = div6_digit({ry_q, cy_q[63:48]});

	logic signed [AccW-1:0] mass_n, momx_n, momy_n;
	assign mass_n = sat_add(mass_q, neg_q ? -$signed(qm_q) : $signed(qm_q));
	assign momx_n = sat_add(momx_q, neg_q ? -$signed(qx_q) : $signed(qx_q));
	assign momy_n = sat_add(momy_q, neg_q ? -$signed(qy_q) : $signed(qy_q));

	// restoring divider for both centroid coordinates
	logic [63:0] dvd_x_q, dvd_y_q, rem_x_q, rem_y_q;
	logic [6:0] cnt_q;
	logic [64:0] tx, ty;
	assign tx = {rem_x_q, dvd_x_q[63]} - {1'b0, mass_q};
	assign ty = {rem_y_q, dvd_y_q[63]} - {1'b0, mass_q};
	assign sts.div_done = (cnt_q == 7'd64);
	assign sts.last = last_q;

	logic [CoordW-1:0] cenx, ceny;
	logic merr;
	always_comb begin
		merr = (mass_q <= 0);
		cenx = (momx_q <= 0 || merr) ? '0 : (dvd_x_q[63:15] != '0) ? CoordMax : dvd_x_q[14:0];
		ceny = (momy_q <= 0 || merr) ? '0 : (dvd_y_q[63:15] != '0) ? CoordMax : dvd_y_q[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= '0;
			momx_q <= '0;
			momy_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.accum) begin
				mass_q <= mass_n;
				momx_q <= momx_n;
				momy_q <= momy_n;
			end
			if (cmd.div_start) cnt_q <= '0;
			else if (cmd.div_step && !sts.div_done) cnt_q <= cnt_q + 7'd1;
			if (cmd.finish) begin
				mass_q <= '0;
				momx_q <= '0;
				momy_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			{by_q, bx_q, ay_q, ax_q, sy_q, sx_q} <= in_data[89:0];
			idx_q <= in_data[97:90];
			last_q <= in_last;
			sm_q <= '0;
			smx_q <= '0;
			smy_q <= '0;
		end
		if (cmd.gauss) begin
			gx_q <= gdiv;
			gy_q <= hdiv;
			neg_q <= det < 0;
			mag_q <= 32'(det < 0 ? -det : det);
		end
		if (cmd.dens) begin
			x2_q <= gx_q * gx_q;
			y2_q <= gy_q * gy_q;
		end
		if (cmd.dens2) d4_q <= 61'(({2'b0, 60'(x2_q) * 60'(x2_q)} + {2'b0, 60'(y2_q) * 60'(y2_q)}) >> 24);
		if (cmd.mom) begin
			sm_q <= sm_q + 50'(dsel);
			smx_q <= smx_q + 65'(dsel) * 65'(gx_q);
			smy_q <= smy_q + 65'(dsel) * 65'(gy_q);
		end
		if (cmd.contrib) begin
			case (cmd.part_sel)
				3'd0: pm_q <= 98'(pprod);
				3'd1: pm_q <= pm_q + {2'b0, pprod, 32'b0};
				3'd2: px_q <= 98'(pprod);
				3'd3: px_q <= px_q + {2'b0, pprod, 32'b0};
				3'd4: py_q <= 98'(pprod);
				default: py_q <= py_q + {2'b0, pprod, 32'b0};
			endcase
		end
		if (cmd.div6) begin
			cm_q <= shr_sat(pm_q);
			cx_q <= shr_sat(px_q);
			cy_q <= shr_sat(py_q);
			rm_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
		end
		if (cmd.quot) begin
			cm_q <= {cm_q[47:0], 16'h0};
			cx_q <= {cx_q[47:0], 16'h0};
			cy_q <= {cy_q[47:0], 16'h0};
			qm_q <= {qm_q[47:0], dm[18:3]};
			qx_q <= {qx_q[47:0], dx[18:3]};
			qy_q <= {qy_q[47:0], dy[18:3]};
			rm_q <= dm[2:0];
			rx_q <= dx[2:0];
			ry_q <= dy[2:0];
		end
		if (cmd.div_start) begin
			dvd_x_q <= momx_n;
			dvd_y_q <= momy_n;
			rem_x_q <= '0;
			rem_y_q <= '0;
		end else if (cmd.div_step && !sts.div_done) begin
			if (!tx[64]) begin
				rem_x_q <= tx[63:0];
				dvd_x_q <= {dvd_x_q[62:0], 1'b1};
			end else begin
				rem_x_q <= {rem_x_q[62:0], dvd_x_q[63]};
				dvd_x_q <= {dvd_x_q[62:0], 1'b0};
			end
			if (!ty[64]) begin
				rem_y_q <= ty[63:0];
				dvd_y_q <= {dvd_y_q[62:0], 1'b1};
			end else begin
				rem_y_q <= {rem_y_q[62:0], dvd_y_q[63]};
				dvd_y_q <= {dvd_y_q[62:0], 1'b0};
			end
		end
	end

	assign res_data = {3'b0, idx_q, (merr ? 63'd0 : mass_q[62:0]), ceny, cenx};
	assign res_err = merr;

	`WCC_ASSERT_NXT(a_sums_clear, clk, arst_n, cmd.finish, mass_q == 0 && momx_q == 0)
	`WCC_ASSERT_IMP(a_mass_bounded, clk, arst_n, 1'b1, mass_q != 64'sh8000_0000_0000_0000)
	`WCC_ASSERT_NXT(a_div_restart, clk, arst_n, cmd.div_start, cnt_q == 0)
endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import wcc_pkg::*;

	typedef struct {
		logic [14:0] cx;
		logic [14:0] cy;
		logic [62:0] mass;
		logic [7:0]  idx;
		logic        err;
	} centroid_res_t;

	typedef struct {
		logic [14:0] sx, sy, ax, ay, bx, by;
		logic [7:0]  idx;
		logic        last;
		logic        typed;   // expected result given in the row
		centroid_res_t res;
	} tri_row_t;

	localparam longint unsigned U63Max = 64'h7fff_ffff_ffff_ffff;
	localparam int WatchLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [103:0] in_word = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic [103:0] out_word;

	assign out_word = 104'(m_axis_tdata);

	always #4 clk = ~clk;

	weighted_cell_centroid_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(in_word[InDataW-1:0]),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// predictor state
	logic   dens_mode = 1'b1;
	longint mass_acc = 0, momx_acc = 0, momy_acc = 0;

	centroid_res_t pending_cells[$];
	int  fail_cnt = 0;
	int  idle_cnt = 0;
	bit  quiet = 1'b0;
	bit  hold_req = 1'b0;

	function automatic longint unsigned gauss_coord(longint unsigned p, q, r);
		return (4 * p + q + r + 3) / 6;
	endfunction

	function automatic longint unsigned dens_at(longint unsigned gx, gy);
		longint unsigned x2, y2;
		if (!dens_mode)
			return 64'd1 << FracW;
		x2 = gx * gx;
		y2 = gy * gy;
		return (x2 * x2 + y2 * y2) >> (3 * FracW);
	endfunction

	function automatic longint scaled_part(bit neg, longint unsigned mag, longint unsigned s);
		logic [127:0] p;
		longint unsigned v;
		p = (128'(mag) * 128'(s)) >> (3 * FracW);
		v = (p > 128'(U63Max)) ? U63Max : p[63:0];
		v = v / 6;
		return neg ? -longint'(v) : longint'(v);
	endfunction

	function automatic longint sum_sat(longint a, longint b);
		longint lim;
		lim = longint'(U63Max);
		if (b > 0 && a > lim - b)
			return lim;
		if (b < 0 && a < -lim - b)
			return -lim;
		return a + b;
	endfunction

	function automatic logic [14:0] coord_quot(longint mom, longint mass);
		longint unsigned q;
		if (mom <= 0)
			return '0;
		q = longint'(mom) / longint'(mass);
		return (q > 32767) ? 15'h7fff : q[14:0];
	endfunction

	// advance the running sums; returns 1 with the centroid on a last triangle
	function automatic bit cell_update(tri_row_t t, output centroid_res_t r);
		longint unsigned px[3], py[3];
		longint unsigned sm, smx, smy, d, mag;
		longint det;
		bit neg;
		px[0] = gauss_coord(t.ax, t.bx, t.sx); py[0] = gauss_coord(t.ay, t.by, t.sy);
		px[1] = gauss_coord(t.bx, t.ax, t.sx); py[1] = gauss_coord(t.by, t.ay, t.sy);
		px[2] = gauss_coord(t.sx, t.ax, t.bx); py[2] = gauss_coord(t.sy, t.ay, t.by);
		sm = 0; smx = 0; smy = 0;
		for (int i = 0; i < 3; i++) begin
			d = dens_at(px[i], py[i]);
			sm += d;
			smx += px[i] * d;
			smy += py[i] * d;
		end
		det = (longint'(t.ax) - longint'(t.sx)) * (longint'(t.by) - longint'(t.sy))
			- (longint'(t.bx) - longint'(t.sx)) * (longint'(t.ay) - longint'(t.sy));
		neg = det < 0;
		mag = neg ? -det : det;
		mass_acc = sum_sat(mass_acc, scaled_part(neg, mag, sm));
		momx_acc = sum_sat(momx_acc, scaled_part(neg, mag, smx));
		momy_acc = sum_sat(momy_acc, scaled_part(neg, mag, smy));
		r = '{default: '0};
		if (!t.last)
			return 1'b0;
		if (mass_acc <= 0) begin
			r.err = 1'b1;
		end else begin
			r.cx = coord_quot(momx_acc, mass_acc);
			r.cy = coord_quot(momy_acc, mass_acc);
			r.mass = mass_acc[62:0];
		end
		r.idx = t.idx;
		mass_acc = 0; momx_acc = 0; momy_acc = 0;
		return 1'b1;
	endfunction

	task automatic gap(int n);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_tri(tri_row_t t);
		centroid_res_t r;
		if (!quiet && $urandom_range(0, 3) == 0)
			gap($urandom_range(1, 13));
		in_word <= 104'({t.idx, t.by, t.bx, t.ay, t.ax, t.sy, t.sx});
		s_axis_tlast <= t.last;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (cell_update(t, r))
			pending_cells = {pending_cells, (t.typed ? t.res : r)};
	endtask

	task automatic drain();
		gap(0);
		while (pending_cells.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic set_mode(logic m);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		dens_mode = m;
	endtask

	function automatic tri_row_t mk_tri(int sx, sy, ax, ay, bx, by, idx, bit last);
		tri_row_t t;
		t = '{default: '0};
		t.sx = 15'(sx); t.sy = 15'(sy); t.ax = 15'(ax); t.ay = 15'(ay);
		t.bx = 15'(bx); t.by = 15'(by);
		t.idx = 8'(idx);
		t.last = last;
		return t;
	endfunction

	function automatic tri_row_t mk_err(tri_row_t t);
		t.typed = 1'b1;
		t.res = '{cx: '0, cy: '0, mass: '0, idx: t.idx, err: 1'b1};
		return t;
	endfunction

	function automatic int clip(int v);
		return (v < 0) ? 0 : (v > 32767) ? 32767 : v;
	endfunction

	// receiver side
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 13);
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		centroid_res_t e, a;
		if (m_axis_tvalid && m_axis_tready) begin
			a.cx = out_word[14:0];
			a.cy = out_word[29:15];
			a.mass = out_word[92:30];
			a.idx = out_word[100:93];
			a.err = m_axis_tuser;
			if (pending_cells.size() == 0) begin
				$display("%0t: unexpected word cx=%0d cy=%0d mass=%0d idx=%0d err=%0d",
					$time, a.cx, a.cy, a.mass, a.idx, a.err);
				fail_cnt++;
			end else begin
				e = pending_cells.pop_front();
				if (a.cx !== e.cx) begin
					$display("%0t: centroid_x exp %0d act %0d", $time, e.cx, a.cx);
					fail_cnt++;
				end
				if (a.cy !== e.cy) begin
					$display("%0t: centroid_y exp %0d act %0d", $time, e.cy, a.cy);
					fail_cnt++;
				end
				if (a.mass !== e.mass) begin
					$display("%0t: cell_mass exp %0d act %0d", $time, e.mass, a.mass);
					fail_cnt++;
				end
				if (a.idx !== e.idx) begin
					$display("%0t: cell_index exp %0d act %0d", $time, e.idx, a.idx);
					fail_cnt++;
				end
				if (a.err !== e.err) begin
					$display("%0t: mass_error exp %0d act %0d", $time, e.err, a.err);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WatchLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		tri_row_t dir_rows[$];
		tri_row_t t;
		int cx0, cy0, rad, ntri, sent;
		longint det;
		logic [14:0] tmp;

		dir_rows = {dir_rows, mk_err(mk_tri(0, 0, 0, 0, 0, 0, 0, 1))};
		dir_rows = {dir_rows, mk_err(mk_tri(0, 0, 100, 100, 200, 200, 255, 1))};
		dir_rows = {dir_rows, mk_err(mk_tri(0, 0, 0, 256, 256, 0, 7, 1))};
		dir_rows = {dir_rows, mk_tri(0, 0, 256, 0, 0, 256, 1, 1)};
		dir_rows = {dir_rows, mk_tri(0, 0, 32767, 0, 0, 32767, 2, 1)};
		dir_rows = {dir_rows, mk_tri(32767, 32767, 0, 32767, 32767, 0, 3, 1)};
		dir_rows = {dir_rows, mk_tri(1000, 1000, 2000, 1000, 1500, 2000, 9, 0)};
		dir_rows = {dir_rows, mk_tri(1000, 1000, 1500, 2000, 500, 1800, 9, 0)};
		dir_rows = {dir_rows, mk_tri(1000, 1000, 500, 1800, 300, 400, 170, 1)};
		// opposite windings cancel to zero mass
		dir_rows = {dir_rows, mk_tri(5000, 5000, 9000, 5000, 7000, 9000, 4, 0)};
		dir_rows = {dir_rows, mk_err(mk_tri(5000, 5000, 7000, 9000, 9000, 5000, 85, 1))};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int pass = 0; pass < 2; pass++) begin
			if (pass == 1)
				set_mode(1'b0);
			foreach (dir_rows[i])
				send_tri(dir_rows[i]);
		end
		set_mode(1'b1);

		sent = 0;
		while (sent < 750) begin
			if (sent >= 250 && sent < 260 && dens_mode)
				set_mode(1'b0);
			if (sent >= 500 && sent < 510 && !dens_mode)
				set_mode(1'b1);
			if (sent >= 400 && sent < 406)
				drain();
			if (sent >= 150 && sent < 156)
				hold_req = 1'b1;
			quiet = sent >= 650;
			ntri = $urandom_range(1, 6);
			case ($urandom_range(0, 9))
				0: rad = 32767;
				1, 2: rad = 64;
				default: rad = $urandom_range(16, 6000);
			endcase
			// an occasional long cell of large triangles drives large running sums
			if ($urandom_range(0, 40) == 0) begin
				ntri = 80;
				rad = 32767;
			end
			cx0 = $urandom_range(0, 32767);
			cy0 = $urandom_range(0, 32767);
			for (int k = 0; k < ntri; k++) begin
				t = mk_tri(cx0, cy0,
					clip(cx0 + $urandom_range(0, 2 * rad) - rad),
					clip(cy0 + $urandom_range(0, 2 * rad) - rad),
					clip(cx0 + $urandom_range(0, 2 * rad) - rad),
					clip(cy0 + $urandom_range(0, 2 * rad) - rad),
					$urandom_range(0, 255), k == ntri - 1);
				if (ntri == 80) begin
					t = (k % 2) ? mk_tri(0, 0, 32767, 0, 32767, 32767, t.idx, t.last)
						: mk_tri(32767, 32767, 0, 32767, 0, 0, t.idx, t.last);
				end else if ($urandom_range(0, 9) == 0) begin
					t = mk_tri($urandom_range(0, 32767), $urandom_range(0, 32767),
						$urandom_range(0, 32767), $urandom_range(0, 32767),
						$urandom_range(0, 32767), $urandom_range(0, 32767),
						t.idx, t.last);
				end
				det = (longint'(t.ax) - t.sx) * (longint'(t.by) - t.sy)
					- (longint'(t.bx) - t.sx) * (longint'(t.ay) - t.sy);
				// keep most triangles counterclockwise
				if (det < 0 && $urandom_range(0, 9) != 0) begin
					tmp = t.ax; t.ax = t.bx; t.bx = tmp;
					tmp = t.ay; t.ay = t.by; t.by = tmp;
				end
				send_tri(t);
				sent++;
			end
		end
		gap(0);
		while (pending_cells.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
